### rtl/core/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp text parser package
// Shared layout constants, the parse state bundle and the decimal helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

    // Text layout: YYYY-MM-DD/HH:MM, sixteen characters.
    localparam int unsigned TEXT_LEN  = 16;
    localparam int unsigned POS_W     = 5;
    localparam logic [POS_W-1:0] POS_DASH_A = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_B = 5'd7;
    localparam logic [POS_W-1:0] POS_SLASH  = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON  = 5'd13;
    localparam logic [POS_W-1:0] POS_END    = 5'(TEXT_LEN);
    localparam logic [POS_W-1:0] POS_FINAL  = 5'(TEXT_LEN - 1);
    localparam logic [POS_W-1:0] POS_YEAR_HI_END = 5'd2;
    localparam logic [POS_W-1:0] POS_YEAR_END    = 5'd4;
    localparam logic [POS_W-1:0] POS_MONTH_END   = 5'd7;
    localparam logic [POS_W-1:0] POS_DAY_END     = 5'd10;
    localparam logic [POS_W-1:0] POS_HOUR_END    = 5'd13;

    // Character codes.
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Calendar limits.
    localparam logic [13:0] YEAR_MIN     = 14'd1000;
    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [6:0]  MONTH_MAX    = 7'd12;
    localparam logic [6:0]  HOUR_LIMIT   = 7'd24;
    localparam logic [6:0]  MINUTE_LIMIT = 7'd60;

    // Month lengths.
    localparam logic [6:0] DAYS_LONG  = 7'd31;
    localparam logic [6:0] DAYS_SHORT = 7'd30;
    localparam logic [6:0] DAYS_LEAP  = 7'd29;
    localparam logic [6:0] DAYS_FEB   = 7'd28;

    // Parse state after the current character has been taken in.
    typedef struct packed {
        logic        final_pos;
        logic        layout_err;
        logic [13:0] year;
        logic [6:0]  year_hi;
        logic [6:0]  year_lo;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
    } tsp_parse_t;

    // Append one decimal digit to a two-digit accumulator.
    function automatic logic [6:0] acc_pair(logic [6:0] acc, logic [3:0] digit);
        logic [10:0] wide;
        wide = {4'b0, acc} * 11'd10 + {7'b0, digit};
        return wide[6:0];
    endfunction

    // Append one decimal digit to the year accumulator.
    function automatic logic [13:0] acc_year(logic [13:0] acc, logic [3:0] digit);
        logic [17:0] wide;
        wide = {4'b0, acc} * 18'd10 + {14'b0, digit};
        return wide[13:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/tsp_char_parser.sv
// ----------------------------------------------------------------------------
// Timestamp character parser
// Holds the position counter, the layout error flag and the decimal field
// accumulators, and works out their values after the current character.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_char_parser
    import tsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    output tsp_parse_t      parse
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             err_reg, err_next;
    logic [13:0]      year_reg, year_next;
    logic [6:0]       year_hi_reg, year_hi_next;
    logic [6:0]       year_lo_reg, year_lo_next;
    logic [6:0]       month_reg, month_next;
    logic [6:0]       day_reg, day_next;
    logic [6:0]       hour_reg, hour_next;
    logic [6:0]       minute_reg, minute_next;
    logic             is_digit;
    logic [3:0]       digit;
    logic [7:0]       digit_wide;

    assign is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit_wide = char_code - CHAR_ZERO;
    assign digit      = is_digit ? digit_wide[3:0] : 4'd0;

    // Layout check and digit accumulation for the current place.
    always_comb
    begin
        err_next     = err_reg;
        year_next    = year_reg;
        year_hi_next = year_hi_reg;
        year_lo_next = year_lo_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        priority if (pos_reg >= POS_END)
        begin
            err_next = 1'b1;
        end
        else if (pos_reg == POS_DASH_A || pos_reg == POS_DASH_B)
        begin
            if (char_code != CHAR_DASH)
                err_next = 1'b1;
        end
        else if (pos_reg == POS_SLASH)
        begin
            if (char_code != CHAR_SLASH)
                err_next = 1'b1;
        end
        else if (pos_reg == POS_COLON)
        begin
            if (char_code != CHAR_COLON)
                err_next = 1'b1;
        end
        else if (!is_digit)
        begin
            err_next = 1'b1;
        end
        else if (pos_reg < POS_YEAR_HI_END)
        begin
            year_next    = acc_year(year_reg, digit);
            year_hi_next = acc_pair(year_hi_reg, digit);
        end
        else if (pos_reg < POS_YEAR_END)
        begin
            year_next    = acc_year(year_reg, digit);
            year_lo_next = acc_pair(year_lo_reg, digit);
        end
        else if (pos_reg < POS_MONTH_END)
        begin
            month_next = acc_pair(month_reg, digit);
        end
        else if (pos_reg < POS_DAY_END)
        begin
            day_next = acc_pair(day_reg, digit);
        end
        else if (pos_reg < POS_HOUR_END)
        begin
            hour_next = acc_pair(hour_reg, digit);
        end
        else
        begin
            minute_next = acc_pair(minute_reg, digit);
        end
    end

    // The position counter saturates one past the last place.
    assign pos_next = (pos_reg < POS_END) ? pos_reg + 5'd1 : pos_reg;

    // State seen by the date check.
    always_comb
    begin
        parse.final_pos  = (pos_reg == POS_FINAL);
        parse.layout_err = err_next;
        parse.year       = year_next;
        parse.year_hi    = year_hi_next;
        parse.year_lo    = year_lo_next;
        parse.month      = month_next;
        parse.day        = day_next;
        parse.hour       = hour_next;
        parse.minute     = minute_next;
    end

    // State registers; a final character returns everything to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            err_reg     <= 1'b0;
            year_reg    <= '0;
            year_hi_reg <= '0;
            year_lo_reg <= '0;
            month_reg   <= '0;
            day_reg     <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
        end
        else if (advance)
        begin
            if (last_char)
            begin
                pos_reg     <= '0;
                err_reg     <= 1'b0;
                year_reg    <= '0;
                year_hi_reg <= '0;
                year_lo_reg <= '0;
                month_reg   <= '0;
                day_reg     <= '0;
                hour_reg    <= '0;
                minute_reg  <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                err_reg     <= err_next;
                year_reg    <= year_next;
                year_hi_reg <= year_hi_next;
                year_lo_reg <= year_lo_next;
                month_reg   <= month_next;
                day_reg     <= day_next;
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/tsp_date_check.sv
// ----------------------------------------------------------------------------
// Timestamp date check
// Decides whether a complete parse forms a valid Gregorian date and time.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_date_check
    import tsp_pkg::*;
(
    input  wire tsp_parse_t parse,
    output logic            date_ok
);

    logic       leap;
    logic [6:0] month_len;

    // Leap year from the two digit pairs: the low pair divisible by four and
    // not zero, or a zero low pair with the century divisible by four.
    assign leap = (parse.year_lo != 7'd0) ? (parse.year_lo[1:0] == 2'b00)
                                          : (parse.year_hi[1:0] == 2'b00);

    // Length of the parsed month; zero for a month out of range.
    always_comb
    begin
        unique case (parse.month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: month_len = DAYS_LONG;
            7'd4, 7'd6, 7'd9, 7'd11:                    month_len = DAYS_SHORT;
            7'd2:    month_len = leap ? DAYS_LEAP : DAYS_FEB;
            default: month_len = 7'd0;
        endcase
    end

    // Layout and calendar checks together.
    assign date_ok = parse.final_pos && !parse.layout_err
                     && (parse.year >= YEAR_MIN) && (parse.year <= YEAR_MAX)
                     && (parse.month != 7'd0) && (parse.month <= MONTH_MAX)
                     && (parse.day != 7'd0) && (parse.day <= month_len)
                     && (parse.hour < HOUR_LIMIT) && (parse.minute < MINUTE_LIMIT);

endmodule

`default_nettype wire

### rtl/core/timestamp_text_parser.sv
// A request taken on char_valid passes through the input register and then the result register to res_valid.
// Throughput: one character per cycle while no final character stalls; only the input register and the result register
// sit in the path, so a character may follow in every cycle.
// A final character stalls only while the previous result is still held by res_stall.
// Reset (rst_n low, asynchronous) clears the parse state, the input valid flag and res_valid.
// ----------------------------------------------------------------------------
// Timestamp text parser
// Checks YYYY-MM-DD/HH:MM text one character at a time and reports the date
// and time fields with a valid flag on the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_text_parser
    import tsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        last_char,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic             valid_res,
    output logic [13:0]      year_out,
    output logic [3:0]       month_out,
    output logic [4:0]       day_out,
    output logic [4:0]       hour_out,
    output logic [5:0]       minute_out
);

    logic        in_valid_reg;
    logic [7:0]  in_code_reg;
    logic        in_last_reg;
    logic        advance;
    logic        date_ok;
    tsp_parse_t  parse;

    logic        res_valid_reg;
    logic        ok_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;

    // A held character moves on unless it is final and the result is blocked.
    assign advance    = in_valid_reg && !(in_last_reg && res_valid_reg && res_stall);
    assign char_stall = in_valid_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            in_code_reg <= char_code;
            in_last_reg <= last_char;
        end
    end

    tsp_char_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .char_code (in_code_reg),
        .last_char (in_last_reg),
        .parse     (parse)
    );

    tsp_date_check u_check (
        .parse   (parse),
        .date_ok (date_ok)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            ok_reg     <= date_ok;
            year_reg   <= date_ok ? parse.year : 14'd0;
            month_reg  <= date_ok ? parse.month[3:0] : 4'd0;
            day_reg    <= date_ok ? parse.day[4:0] : 5'd0;
            hour_reg   <= date_ok ? parse.hour[4:0] : 5'd0;
            minute_reg <= date_ok ? parse.minute[5:0] : 6'd0;
        end
    end

    assign res_valid  = res_valid_reg;
    assign valid_res  = ok_reg;
    assign year_out   = year_reg;
    assign month_out  = month_reg;
    assign day_out    = day_reg;
    assign hour_out   = hour_reg;
    assign minute_out = minute_reg;

endmodule

`default_nettype wire
